FILE: design/bfss_pkg.sv
`timescale 1ns / 1ps

package bfss_pkg;

    localparam int STORE_BYTES    = 4096;
    localparam int MAX_FIELD_BITS = 64;
    localparam int FIELD_W        = 64;
    localparam int STORE_BITS     = STORE_BYTES * 8;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int CUR_W          = $clog2(STORE_BITS + 1);
    localparam int START_W        = (CUR_W > 15) ? CUR_W : 15;
    localparam int SUM_W          = START_W + 1;
    localparam int MAX_BYTES      = (MAX_FIELD_BITS + 7 + 7) / 8;
    localparam int WIN_W          = MAX_BYTES * 8;
    localparam int NB_W           = $clog2(MAX_BYTES + 1);
    localparam int SH_W           = $clog2(WIN_W);

    typedef enum logic [2:0] {
        MODE_RD_CUR = 3'd0,
        MODE_WR_CUR = 3'd1,
        MODE_SKIP   = 3'd2,
        MODE_RD_ABS = 3'd3,
        MODE_WR_ABS = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_XFER,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              xfer;
        logic [NB_W-1:0]   nb;
        logic [ADDR_W-1:0] tail_byte;
    } setup_t;

    typedef struct packed {
        logic ready;
        logic load_item;
        logic setup;
        logic proc;
        logic load_out;
        logic clearing;
    } ctrl_t;

endpackage

FILE: design/bit_field_stream_store_core.sv
`timescale 1ns / 1ps

// Bit-addressed byte store with MSB-first bit order. After reset the block
// zeroes every byte of the memory and takes no item meanwhile. An item
// that reads or writes a field spanning nb bytes (1 to 9) passes a setup
// step, then reads each byte through the single byte-wide memory read port
// and merges it, and then loads the output register. Skips, zero-count
// items, unused modes and out-of-range items go from setup straight to the
// output register. The next item is accepted while a finished result still
// waits in the output register.
module bit_field_stream_store_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   mode,
    input  logic [14:0]                  bit_address,
    input  logic [6:0]                   bit_count,
    input  logic [bfss_pkg::FIELD_W-1:0] write_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bfss_pkg::FIELD_W-1:0] read_value,
    output logic [15:0]                  cursor_now,
    output logic                         status
);
    import bfss_pkg::*;

    ctrl_t             ctrl;
    setup_t            info;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        rd_data;
    logic [7:0]        wdata;
    logic              mem_we;

    logic [2:0]         mode_reg;
    logic [14:0]        addr_reg;
    logic [6:0]         count_reg;
    logic [FIELD_W-1:0] wval_reg;
    logic [CUR_W-1:0]   cursor_reg, cursor_next;

    logic [START_W-1:0] start;
    logic [SUM_W-1:0]   end_sum;
    logic [SUM_W-1:0]   end_m1;
    logic               is_rd, is_wr, is_field, noop, err;
    logic [7:0]         span;
    logic [7:0]         nb_full;
    logic [2:0]         pad;
    logic [FIELD_W-1:0] fmask;

    logic               status_reg;
    logic               rd_sel_reg;
    logic               wr_sel_reg;
    logic [SH_W-1:0]    rsh_reg;
    logic [FIELD_W-1:0] rmask_reg;
    logic [WIN_W-1:0]   wwin_reg;
    logic [WIN_W-1:0]   mwin_reg;
    logic [WIN_W-1:0]   acc_reg;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] rd_out_reg;
    logic [FIELD_W-1:0] rd_final;
    logic [15:0]        cur_out_reg;
    logic               status_out_reg;

    bfss_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_valid_reg && out_stall),
        .info     (info),
        .ctrl     (ctrl),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    bfss_mem u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wdata   (wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Setup decode works on the captured item and the current cursor.
    always_comb
    begin
        is_rd    = (mode_reg == MODE_RD_CUR) || (mode_reg == MODE_RD_ABS);
        is_wr    = (mode_reg == MODE_WR_CUR) || (mode_reg == MODE_WR_ABS);
        is_field = (mode_reg != MODE_SKIP);
        start    = (mode_reg == MODE_RD_ABS || mode_reg == MODE_WR_ABS)
                   ? START_W'(addr_reg) : START_W'(cursor_reg);
        end_sum  = SUM_W'(start) + SUM_W'(count_reg);
        end_m1   = end_sum - SUM_W'(1);
        noop     = (count_reg == '0) || (mode_reg > MODE_WR_ABS);
        err      = !noop && ((is_field && count_reg > 7'(MAX_FIELD_BITS))
                             || end_sum > SUM_W'(STORE_BITS));
        span     = 8'(start[2:0]) + 8'(count_reg);
        nb_full  = (span + 8'd7) >> 3;
        pad      = 3'(8'd0 - span);
        fmask    = {FIELD_W{1'b1}} >> (7'(FIELD_W) - count_reg);

        info.xfer      = !noop && !err && (is_rd || is_wr);
        info.nb        = NB_W'(nb_full);
        info.tail_byte = end_m1[ADDR_W+2:3];
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        if (ctrl.setup && !noop && !err && mode_reg <= MODE_SKIP)
        begin
            cursor_next = CUR_W'(end_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The field is placed in a byte window aligned to the store's bytes, its last
    // bit pad bits above the bottom; the window then moves one byte at a time.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            mode_reg  <= mode;
            addr_reg  <= bit_address;
            count_reg <= bit_count;
            wval_reg  <= write_value;
        end
        if (ctrl.setup)
        begin
            status_reg <= err;
            rd_sel_reg <= info.xfer && is_rd;
            wr_sel_reg <= info.xfer && is_wr;
            rsh_reg    <= SH_W'(WIN_W) - (SH_W'(info.nb) << 3) + SH_W'(pad);
            rmask_reg  <= fmask;
            wwin_reg   <= WIN_W'(wval_reg & fmask) << pad;
            mwin_reg   <= WIN_W'(fmask) << pad;
            acc_reg    <= '0;
        end
        else if (ctrl.proc)
        begin
            wwin_reg <= wwin_reg >> 8;
            mwin_reg <= mwin_reg >> 8;
            acc_reg  <= {rd_data, acc_reg[WIN_W-1:8]};
        end
        if (ctrl.load_out)
        begin
            rd_out_reg     <= rd_sel_reg ? rd_final : '0;
            cur_out_reg    <= 16'(cursor_reg);
            status_out_reg <= status_reg;
        end
    end

    assign rd_final = FIELD_W'(acc_reg >> rsh_reg) & rmask_reg;

    assign mem_we = ctrl.clearing || (ctrl.proc && wr_sel_reg);
    assign wdata  = ctrl.clearing ? 8'h00
                    : ((rd_data & ~mwin_reg[7:0]) | (wwin_reg[7:0] & mwin_reg[7:0]));

    assign in_stall   = !ctrl.ready;
    assign out_valid  = out_valid_reg;
    assign read_value = rd_out_reg;
    assign cursor_now = cur_out_reg;
    assign status     = status_out_reg;

endmodule

FILE: design/bfss_mem.sv
`timescale 1ns / 1ps

module bfss_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [bfss_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                  wdata,
    input  logic                        rd_en,
    input  logic [bfss_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                  rd_data
);
    import bfss_pkg::*;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bfss_seq.sv
`timescale 1ns / 1ps

module bfss_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        out_busy,
    input  bfss_pkg::setup_t            info,
    output bfss_pkg::ctrl_t             ctrl,
    output logic                        rd_en,
    output logic [bfss_pkg::ADDR_W-1:0] rd_addr,
    output logic [bfss_pkg::ADDR_W-1:0] wr_addr
);
    import bfss_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] issue_addr_reg, issue_addr_next;
    logic [NB_W-1:0]   issue_left_reg, issue_left_next;
    logic [NB_W-1:0]   proc_left_reg, proc_left_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              clear_done;

    assign clear_done = (clr_reg == ADDR_W'(STORE_BYTES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            issue_addr_reg <= '0;
            issue_left_reg <= '0;
            proc_left_reg  <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            issue_addr_reg <= issue_addr_next;
            issue_left_reg <= issue_left_next;
            proc_left_reg  <= proc_left_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = info.xfer ? ST_XFER : ST_OUT;
            end
            ST_XFER:
            begin
                if (pend_reg && proc_left_reg == NB_W'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Reads are issued from the last byte down to the first; the data of a
    // read is merged in the cycle after it is issued, while the next read is issued.
    always_comb
    begin
        clr_next        = clr_reg;
        issue_addr_next = issue_addr_reg;
        issue_left_next = issue_left_reg;
        proc_left_next  = proc_left_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
            end
            ST_SETUP:
            begin
                issue_addr_next = info.tail_byte;
                issue_left_next = info.nb;
                proc_left_next  = info.nb;
            end
            ST_XFER:
            begin
                if (issue_left_reg != '0)
                begin
                    issue_addr_next = issue_addr_reg - ADDR_W'(1);
                    issue_left_next = issue_left_reg - NB_W'(1);
                    pend_next       = 1'b1;
                    pend_addr_next  = issue_addr_reg;
                end
                if (pend_reg)
                begin
                    proc_left_next = proc_left_reg - NB_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ctrl    = '0;
        rd_en   = 1'b0;
        rd_addr = issue_addr_reg;
        wr_addr = pend_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clearing = 1'b1;
                wr_addr       = clr_reg;
            end
            ST_IDLE:
            begin
                ctrl.ready     = 1'b1;
                ctrl.load_item = in_valid;
            end
            ST_SETUP:
            begin
                ctrl.setup = 1'b1;
            end
            ST_XFER:
            begin
                rd_en     = (issue_left_reg != '0);
                ctrl.proc = pend_reg;
            end
            ST_OUT:
            begin
                ctrl.load_out = !out_busy;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: verif/bit_field_stream_store_core_tb.sv
`timescale 1ns / 1ps

module bit_field_stream_store_core_tb;

    import bfss_pkg::*;

    localparam int RANDOM_ITEMS = 1025;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [63:0] read_value;
        logic [15:0] cursor;
        logic        status;
    } field_result_t;

    // Mirrors the byte store and the bit cursor and keeps the results that
    // accepted items still owe.
    class field_store_scoreboard;
        logic [7:0]    store_bytes [STORE_BYTES];
        int unsigned   cursor;
        field_result_t expected_fields [$];
        int            mismatch_count;
        int            results_checked;
        int            range_errors;

        function new();
            foreach (store_bytes[i])
                store_bytes[i] = 8'h00;
            cursor = 0;
            mismatch_count = 0;
            results_checked = 0;
            range_errors = 0;
        endfunction

        // Bit p sits in byte p/8 at bit 7-(p%8); the first bit read ends up
        // as the most significant bit of the field.
        function logic [63:0] take_bits(int unsigned start, int unsigned n);
            logic [63:0] acc;
            int unsigned p;
            acc = '0;
            for (int unsigned i = 0; i < n; i++)
            begin
                p = start + i;
                acc = {acc[62:0], store_bytes[p >> 3][7 - (p & 7)]};
            end
            return acc;
        endfunction

        function void put_bits(int unsigned start, int unsigned n, logic [63:0] value);
            int unsigned p;
            for (int unsigned i = 0; i < n; i++)
            begin
                p = start + i;
                store_bytes[p >> 3][7 - (p & 7)] = value[n - 1 - i];
            end
        endfunction

        function void apply_item(logic [2:0] m, logic [14:0] addr, logic [6:0] n,
                                 logic [63:0] value);
            field_result_t r;
            int unsigned   start;
            r = '0;
            if (n != 0 && m <= MODE_WR_ABS)
            begin
                start = (m >= MODE_RD_ABS) ? int'(addr) : cursor;
                if ((m != MODE_SKIP && n > MAX_FIELD_BITS) || start + n > STORE_BITS)
                begin
                    r.status = 1'b1;
                    range_errors++;
                end
                else if (m == MODE_RD_CUR || m == MODE_RD_ABS)
                    r.read_value = take_bits(start, n);
                else if (m == MODE_WR_CUR || m == MODE_WR_ABS)
                    put_bits(start, n, value);
                if (!r.status && m <= MODE_SKIP)
                    cursor = start + n;
            end
            r.cursor = cursor[15:0];
            expected_fields = {expected_fields, r};
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatch_count++;
        endtask

        task check_result(logic [63:0] rv, logic [15:0] cur, logic st);
            field_result_t want;
            if (expected_fields.size() == 0)
            begin
                report($sformatf("unexpected result read_value=%h cursor=%0d status=%0d",
                                 rv, cur, st));
                return;
            end
            want = expected_fields.pop_front();
            results_checked++;
            if (rv !== want.read_value)
                report($sformatf("read_value got %h want %h", rv, want.read_value));
            if (cur !== want.cursor)
                report($sformatf("cursor_now got %0d want %0d", cur, want.cursor));
            if (st !== want.status)
                report($sformatf("status got %0d want %0d", st, want.status));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  mode;
    logic [14:0] bit_address;
    logic [6:0]  bit_count;
    logic [63:0] write_value;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] read_value;
    logic [15:0] cursor_now;
    logic        status;

    field_store_scoreboard sb;
    int cycle_count = 0;
    int items_sent = 0;
    bit no_idle = 1'b0;

    bit_field_stream_store_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .bit_address (bit_address),
        .bit_count   (bit_count),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .cursor_now  (cursor_now),
        .status      (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(read_value, cursor_now, status);
    end

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // Returns at the clock step in which the item was accepted, with valid
    // still high so that a following item can go out back to back.
    task automatic send_item(logic [2:0] m, logic [14:0] addr, logic [6:0] n,
                             logic [63:0] value);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        bit_address <= addr;
        bit_count   <= n;
        write_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        sb.apply_item(m, addr, n, value);
        items_sent++;
    endtask

    task automatic receive_results();
        int hold;
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    endtask

    function automatic logic [6:0] pick_count();
        int q;
        q = $urandom_range(0, 19);
        if (q == 0)
            return 7'd0;
        if (q == 1)
            return 7'($urandom_range(65, 127));
        if (q == 2)
            return 7'd64;
        if (q < 6)
            return 7'($urandom_range(1, 8));
        return 7'($urandom_range(0, 64));
    endfunction

    task automatic send_random_item();
        logic [2:0]  m;
        logic [6:0]  n;
        int          a;
        int          back;
        logic [63:0] value;
        if ($urandom_range(0, 99) < 4)
            m = 3'($urandom_range(5, 7));
        else
            m = 3'($urandom_range(0, 4));
        n = pick_count();
        if (m == MODE_SKIP && $urandom_range(0, 3) == 0)
            n = 7'($urandom_range(0, 127));
        // Absolute addresses cluster where data was written and around the
        // store end, so reads see real content and range checks get exercised.
        case ($urandom_range(0, 3))
            0: a = $urandom_range(0, 32767);
            1: a = STORE_BITS - int'(n) + $urandom_range(0, 2) - 1;
            2: a = $urandom_range(0, 1023);
            default:
            begin
                back = $urandom_range(0, 256);
                a = (sb.cursor > back) ? int'(sb.cursor) - back : 0;
            end
        endcase
        value = {$urandom, $urandom};
        send_item(m, 15'(a), n, value);
    endtask

    task automatic run_directed();
        send_item(MODE_WR_CUR, 15'd0, 7'd64, 64'hffff_ffff_ffff_ffff);
        send_item(MODE_RD_ABS, 15'd0, 7'd64, 64'h0);
        send_item(MODE_WR_ABS, 15'd3, 7'd13, 64'h5a5a_5a5a_5a5a_1234);
        send_item(MODE_RD_ABS, 15'd0, 7'd24, 64'h0);
        send_item(MODE_RD_CUR, 15'd0, 7'd1, 64'h0);
        send_item(MODE_WR_CUR, 15'h7fff, 7'd7, 64'hffff_ffff_ffff_ff55);
        // A zero count leaves everything alone in every mode.
        for (int i = 0; i <= MODE_WR_ABS; i++)
            send_item(3'(i), 15'd8, 7'd0, 64'hffff_ffff_ffff_ffff);
        // Fields wider than the limit are refused, while skip takes any count.
        send_item(MODE_RD_CUR, 15'd0, 7'd65, 64'h0);
        send_item(MODE_WR_CUR, 15'd0, 7'd127, 64'hffff_ffff_ffff_ffff);
        send_item(MODE_RD_ABS, 15'd0, 7'd100, 64'h0);
        send_item(MODE_WR_ABS, 15'd0, 7'd65, 64'hffff_ffff_ffff_ffff);
        send_item(MODE_SKIP, 15'd0, 7'd127, 64'h0);
        for (int i = 5; i <= 7; i++)
            send_item(3'(i), 15'd0, 7'd10, 64'hffff_ffff_ffff_ffff);
        // A field may end exactly at the store end but not one bit beyond.
        send_item(MODE_WR_ABS, 15'(STORE_BITS - 64), 7'd64, 64'h8123_4567_89ab_cdef);
        send_item(MODE_RD_ABS, 15'(STORE_BITS - 64), 7'd64, 64'h0);
        send_item(MODE_WR_ABS, 15'(STORE_BITS - 63), 7'd64, 64'hffff_ffff_ffff_ffff);
        send_item(MODE_RD_ABS, 15'h7fff, 7'd1, 64'h0);
        send_item(MODE_RD_ABS, 15'h7fff, 7'd2, 64'h0);
        send_item(MODE_RD_ABS, 15'd7, 7'd64, 64'h0);
    endtask

    initial
    begin
        int k;
        sb = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= MODE_RD_CUR;
        bit_address <= '0;
        bit_count   <= '0;
        write_value <= '0;
        out_stall   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        fork
            receive_results();
        join_none
        run_directed();
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // Toward the end, walk the cursor up to the store end with long
            // skips so that cursor items also meet the end of the store.
            if (k >= RANDOM_ITEMS - 250 && sb.cursor + 300 < STORE_BITS
                && $urandom_range(0, 3) != 0)
                send_item(MODE_SKIP, 15'($urandom), 7'd127, {$urandom, $urandom});
            else
                send_random_item();
        end
        in_valid <= 1'b0;
        while (sb.expected_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items and checked %0d results, %0d of them out-of-range refusals.",
                 items_sent, sb.results_checked, sb.range_errors);
        $display("Final bit cursor %0d of %0d, mismatches %0d.",
                 sb.cursor, STORE_BITS, sb.mismatch_count);
        if (sb.mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
